@@ rtl/hhn_pkg.sv @@
// Shared types and constants of the heightfield height and normal sampler.
// Used by the front end, the sequencer, the top level and the testbench; depends on nothing.
`default_nettype none
package hhn_pkg;

   localparam int CHUNK_TILES_DEF    = 32;
   localparam int TILE_SIZE_LOG2_DEF = 0;
   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int QUEUE_DEPTH        = 4;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_HEIGHT = 2'd1;
   localparam logic [1:0] CMD_NORMAL = 2'd2;

   localparam logic [1:0] REG_PRESENT = 2'd0;
   localparam logic [1:0] REG_CHUNK_X = 2'd1;
   localparam logic [1:0] REG_CHUNK_Z = 2'd2;
   localparam logic [1:0] REG_SCALE   = 2'd3;

   localparam int EPS_Q8  = 26;
   localparam int ONE_Q14 = 16384;
   localparam logic signed [31:0] MISS_HEIGHT = -32'sd25344;
   localparam logic [15:0] SCALE_RESET = 16'd256;

   typedef enum logic [2:0] {
      KIND_WRITE,
      KIND_HEIGHT,
      KIND_NORMAL,
      KIND_MISS_H,
      KIND_MISS_N
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOC,
      ST_TILE,
      ST_BASE,
      ST_READ,
      ST_SCLO,
      ST_SCHI,
      ST_SCFIN,
      ST_ABS,
      ST_NORM,
      ST_SQ,
      ST_SQRT,
      ST_DSET,
      ST_DIV,
      ST_DFIN,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

@@ rtl/hhn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module hhn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1089,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ rtl/hhn_fifo.sv @@
// Short queue between the front end and the sequencer.
// Depends on nothing.
`default_nettype none
module hhn_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rptr_ff];

endmodule
`default_nettype wire

@@ rtl/hhn_front.sv @@
// Front end: classifies each accepted transaction and moves it into chunk-local
// coordinates before it enters the queue. Depends on hhn_pkg.
`default_nettype none
module hhn_front #(
   parameter int CHUNK_TILES    = hhn_pkg::CHUNK_TILES_DEF,
   parameter int TILE_SIZE_LOG2 = hhn_pkg::TILE_SIZE_LOG2_DEF,
   parameter int SAMPLE_BITS    = hhn_pkg::SAMPLE_BITS_DEF,
   localparam int SH   = TILE_SIZE_LOG2 + 8,
   localparam int TW   = $clog2(CHUNK_TILES + 1),
   localparam int LW   = 34 + TW + SH,
   localparam int SIDE = CHUNK_TILES + 1,
   localparam int AW   = $clog2(SIDE * SIDE),
   localparam int SW   = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16,
   localparam int QW   = 3 + 2 * LW + AW + SW
) (
   input  logic               accept,
   input  logic [1:0]         command,
   input  logic signed [31:0] pos_x,
   input  logic signed [31:0] pos_z,
   input  logic [5:0]         grid_row,
   input  logic [5:0]         grid_col,
   input  logic [15:0]        sample,
   input  logic               present,
   input  logic signed [15:0] chunk_x,
   input  logic signed [15:0] chunk_z,
   output logic               push,
   output logic [QW-1:0]      qdata
);

   import hhn_pkg::*;

   kind_type                kind;
   logic                    keep;
   logic signed [LW-1:0]    base_x, base_z, bx, bz;
   logic [AW-1:0]           addr;

   always_comb begin
      base_x = (LW'(chunk_x) * LW'(CHUNK_TILES)) <<< SH;
      base_z = (LW'(chunk_z) * LW'(CHUNK_TILES)) <<< SH;
      bx     = LW'(pos_x) - base_x;
      bz     = LW'(pos_z) - base_z;
      addr   = AW'(int'(grid_row) * SIDE + int'(grid_col));
      kind   = KIND_WRITE;
      keep   = 1'b0;
      unique case (command)
         CMD_WRITE: begin
            kind = KIND_WRITE;
            keep = (int'(grid_row) <= CHUNK_TILES) && (int'(grid_col) <= CHUNK_TILES);
         end
         CMD_HEIGHT: begin
            kind = present ? KIND_HEIGHT : KIND_MISS_H;
            keep = 1'b1;
         end
         CMD_NORMAL: begin
            kind = present ? KIND_NORMAL : KIND_MISS_N;
            keep = 1'b1;
         end
         default: begin
            kind = KIND_WRITE;
            keep = 1'b0;
         end
      endcase
   end

   assign push  = accept && keep;
   assign qdata = {sample[SW-1:0], addr, bz, bx, kind};

endmodule
`default_nettype wire

@@ rtl/hhn_back.sv @@
// Sequencer: holds the height grid, interpolates heights, builds and normalises
// normals and drives the result register. Depends on hhn_pkg and hhn_ram.
`default_nettype none
module hhn_back #(
   parameter int CHUNK_TILES    = hhn_pkg::CHUNK_TILES_DEF,
   parameter int TILE_SIZE_LOG2 = hhn_pkg::TILE_SIZE_LOG2_DEF,
   parameter int SAMPLE_BITS    = hhn_pkg::SAMPLE_BITS_DEF,
   localparam int SH   = TILE_SIZE_LOG2 + 8,
   localparam int TW   = $clog2(CHUNK_TILES + 1),
   localparam int LW   = 34 + TW + SH,
   localparam int SIDE = CHUNK_TILES + 1,
   localparam int AW   = $clog2(SIDE * SIDE),
   localparam int SW   = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16,
   localparam int QW   = 3 + 2 * LW + AW + SW
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  logic [QW-1:0] q_rdata,
   output logic          q_pop,
   input  logic [15:0]   scale,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [79:0]   rsp_tdata,
   output logic [0:0]    rsp_tuser
);

   import hhn_pkg::*;

   localparam int D     = 1 << SH;
   localparam int SUM_W = SW + SH + 2;
   localparam int LO_W  = 17;
   localparam int HI_W  = SUM_W - LO_W;
   localparam int PW    = SUM_W + 17;
   localparam int VW    = PW + 1;
   localparam int WW    = SH + 3;

   localparam logic signed [LW-1:0] EPS   = LW'(EPS_Q8);
   localparam logic signed [PW-1:0] H_MAX = PW'(32'sh7fff_ffff);
   localparam logic signed [PW-1:0] H_MIN = PW'(32'sh8000_0000);

   state_type            state_ff, state_in;
   kind_type             kind_ff, kind_in, qkind;
   logic signed [LW-1:0] bx_ff, bx_in, bz_ff, bz_in, lx_ff, lx_in, lz_ff, lz_in;
   logic signed [LW-1:0] offx, offz;
   logic [1:0]           k_ff, k_in, rd_ff, rd_in, j_ff, j_in;
   logic [TW-1:0]        tx_ff, tx_in, tz_ff, tz_in;
   logic [SH:0]          fx_ff, fx_in, fz_ff, fz_in;
   logic                 upper_ff, upper_in;
   logic [AW-1:0]        abase_ff, abase_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in, rds, ws;
   logic signed [WW-1:0] fxs, fzs, ds, w;
   logic [LO_W+15:0]     plo_ff, plo_in;
   logic signed [HI_W+16:0] phi_ff, phi_in;
   logic signed [PW-1:0] full, hval;
   logic signed [VW-1:0] va_ff, va_in, vc_ff, vc_in;
   logic [VW-1:0]        m0_ff, m0_in, m1_ff, m1_in, m2_ff, m2_in;
   logic                 neg0_ff, neg0_in, neg2_ff, neg2_in, negsel;
   logic [29:0]          msel;
   logic [59:0]          prod60;
   logic [63:0]          sq_ff, sq_in, root_ff, root_in, bitv, trial;
   logic [4:0]           bp_ff, bp_in, cnt_ff, cnt_in;
   logic [31:0]          len_ff, len_in, drem_ff, drem_in;
   logic [45:0]          num;
   logic [15:0]          numlo_ff, numlo_in, q_ff, q_in, qc, comp;
   logic [32:0]          dtrial;
   logic signed [31:0]   res_h_ff, res_h_in;
   logic [15:0]          res_nx_ff, res_nx_in, res_ny_ff, res_ny_in, res_nz_ff, res_nz_in;
   logic                 res_miss_ff, res_miss_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [79:0]          rsp_data_ff, rsp_data_in;
   logic                 rsp_miss_ff, rsp_miss_in;
   logic                 ram_we;
   logic [AW-1:0]        ram_raddr;
   logic [SW-1:0]        ram_rdata;

   function automatic logic [TW-1:0] tile_of(input logic signed [LW-1:0] l);
      logic signed [LW-1:0] t;
      t = l >>> SH;
      if (t < 0) begin
         t = '0;
      end else if (t > LW'(CHUNK_TILES - 1)) begin
         t = LW'(CHUNK_TILES - 1);
      end
      return t[TW-1:0];
   endfunction

   function automatic logic [SH:0] frac_of(input logic signed [LW-1:0] l,
                                           input logic [TW-1:0] t);
      logic signed [LW-1:0] f;
      f = l - (LW'(t) <<< SH);
      if (f < 0) begin
         f = '0;
      end else if (f > LW'(D)) begin
         f = LW'(D);
      end
      return f[SH:0];
   endfunction

   hhn_ram #(
      .WIDTH (SW),
      .DEPTH (SIDE * SIDE)
   ) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (q_rdata[3+2*LW+AW-1:3+2*LW]),
      .wdata (q_rdata[QW-1:3+2*LW+AW]),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      qkind = kind_type'(q_rdata[2:0]);
      offx  = '0;
      offz  = '0;
      if (kind_ff == KIND_NORMAL) begin
         unique case (k_ff)
            2'd0: offx = -EPS;
            2'd1: offx = EPS;
            2'd2: offz = -EPS;
            2'd3: offz = EPS;
            default: offx = '0;
         endcase
      end
      fxs = $signed(WW'(fx_ff));
      fzs = $signed(WW'(fz_ff));
      ds  = WW'(D);
      unique case (rd_ff)
         2'd1:    w = upper_ff ? fxs + fzs - ds : ds - fxs - fzs;
         2'd2:    w = upper_ff ? ds - fzs : fxs;
         default: w = upper_ff ? ds - fxs : fzs;
      endcase
      unique case (rd_ff)
         2'd0:    ram_raddr = upper_ff ? AW'(int'(abase_ff) + SIDE + 1) : abase_ff;
         2'd1:    ram_raddr = AW'(int'(abase_ff) + 1);
         default: ram_raddr = AW'(int'(abase_ff) + SIDE);
      endcase
      rds  = SUM_W'($signed(ram_rdata));
      ws   = SUM_W'(w);
      full = (PW'(phi_ff) <<< LO_W) + $signed(PW'(plo_ff));
      hval = full >>> SH;
      unique case (j_ff)
         2'd0:    begin msel = m0_ff[29:0]; negsel = neg0_ff; end
         2'd1:    begin msel = m1_ff[29:0]; negsel = 1'b0; end
         default: begin msel = m2_ff[29:0]; negsel = neg2_ff; end
      endcase
      prod60 = msel * msel;
      bitv   = 64'd1 << {bp_ff, 1'b0};
      trial  = root_ff + bitv;
      num    = 46'({msel, 14'b0}) + 46'(len_ff >> 1);
      dtrial = {drem_ff, numlo_ff[15]};
      qc     = (q_ff > 16'(ONE_Q14)) ? 16'(ONE_Q14) : q_ff;
      comp   = negsel ? -qc : qc;
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      bx_in       = bx_ff;
      bz_in       = bz_ff;
      lx_in       = lx_ff;
      lz_in       = lz_ff;
      k_in        = k_ff;
      rd_in       = rd_ff;
      j_in        = j_ff;
      tx_in       = tx_ff;
      tz_in       = tz_ff;
      fx_in       = fx_ff;
      fz_in       = fz_ff;
      upper_in    = upper_ff;
      abase_in    = abase_ff;
      acc_in      = acc_ff;
      plo_in      = plo_ff;
      phi_in      = phi_ff;
      va_in       = va_ff;
      vc_in       = vc_ff;
      m0_in       = m0_ff;
      m1_in       = m1_ff;
      m2_in       = m2_ff;
      neg0_in     = neg0_ff;
      neg2_in     = neg2_ff;
      sq_in       = sq_ff;
      root_in     = root_ff;
      bp_in       = bp_ff;
      len_in      = len_ff;
      drem_in     = drem_ff;
      numlo_in    = numlo_ff;
      q_in        = q_ff;
      cnt_in      = cnt_ff;
      res_h_in    = res_h_ff;
      res_nx_in   = res_nx_ff;
      res_ny_in   = res_ny_ff;
      res_nz_in   = res_nz_ff;
      res_miss_in = res_miss_ff;
      rsp_data_in = rsp_data_ff;
      rsp_miss_in = rsp_miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      q_pop       = 1'b0;
      ram_we      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop       = 1'b1;
               kind_in     = qkind;
               bx_in       = $signed(q_rdata[LW+2:3]);
               bz_in       = $signed(q_rdata[2*LW+2:LW+3]);
               k_in        = 2'd0;
               res_h_in    = '0;
               res_nx_in   = '0;
               res_ny_in   = '0;
               res_nz_in   = '0;
               res_miss_in = 1'b0;
               unique case (qkind)
                  KIND_WRITE: ram_we = 1'b1;
                  KIND_HEIGHT, KIND_NORMAL: state_in = ST_LOC;
                  KIND_MISS_H: begin
                     res_h_in    = MISS_HEIGHT;
                     res_miss_in = 1'b1;
                     state_in    = ST_OUT;
                  end
                  KIND_MISS_N: begin
                     res_ny_in   = 16'(ONE_Q14);
                     res_miss_in = 1'b1;
                     state_in    = ST_OUT;
                  end
                  default: ram_we = 1'b0;
               endcase
            end
         end
         ST_LOC: begin
            lx_in    = bx_ff + offx;
            lz_in    = bz_ff + offz;
            state_in = ST_TILE;
         end
         ST_TILE: begin
            tx_in    = tile_of(lx_ff);
            tz_in    = tile_of(lz_ff);
            fx_in    = frac_of(lx_ff, tx_in);
            fz_in    = frac_of(lz_ff, tz_in);
            upper_in = ({1'b0, fx_in} + {1'b0, fz_in}) > (SH + 2)'(D);
            state_in = ST_BASE;
         end
         ST_BASE: begin
            abase_in = AW'(int'(tz_ff) * SIDE + int'(tx_ff));
            rd_in    = 2'd0;
            state_in = ST_READ;
         end
         ST_READ: begin
            acc_in = (rd_ff == 2'd0) ? '0 : acc_ff + rds * ws;
            rd_in  = rd_ff + 2'd1;
            if (rd_ff == 2'd3) begin
               state_in = ST_SCLO;
            end
         end
         ST_SCLO: begin
            plo_in   = acc_ff[LO_W-1:0] * scale;
            state_in = ST_SCHI;
         end
         ST_SCHI: begin
            phi_in   = $signed(acc_ff[SUM_W-1:LO_W]) * $signed({1'b0, scale});
            state_in = ST_SCFIN;
         end
         ST_SCFIN: begin
            if (kind_ff == KIND_HEIGHT) begin
               if (hval > H_MAX) begin
                  res_h_in = 32'sh7fff_ffff;
               end else if (hval < H_MIN) begin
                  res_h_in = 32'sh8000_0000;
               end else begin
                  res_h_in = hval[31:0];
               end
               state_in = ST_OUT;
            end else begin
               unique case (k_ff)
                  2'd0:    va_in = VW'(hval);
                  2'd1:    va_in = va_ff - VW'(hval);
                  2'd2:    vc_in = VW'(hval);
                  default: vc_in = vc_ff - VW'(hval);
               endcase
               k_in     = k_ff + 2'd1;
               state_in = (k_ff == 2'd3) ? ST_ABS : ST_LOC;
            end
         end
         ST_ABS: begin
            neg0_in  = va_ff < 0;
            neg2_in  = vc_ff < 0;
            m0_in    = (va_ff < 0) ? VW'(-va_ff) : VW'(va_ff);
            m1_in    = VW'(2 * EPS_Q8);
            m2_in    = (vc_ff < 0) ? VW'(-vc_ff) : VW'(vc_ff);
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if ((m0_ff[VW-1:30] != '0) || (m1_ff[VW-1:30] != '0) ||
                (m2_ff[VW-1:30] != '0)) begin
               m0_in = m0_ff >> 1;
               m1_in = m1_ff >> 1;
               m2_in = m2_ff >> 1;
            end else begin
               j_in     = 2'd0;
               sq_in    = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sq_in = sq_ff + 64'(prod60);
            j_in  = j_ff + 2'd1;
            if (j_ff == 2'd2) begin
               root_in  = '0;
               bp_in    = 5'd31;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_ff >= trial) begin
               sq_in   = sq_ff - trial;
               root_in = (root_ff >> 1) + bitv;
            end else begin
               root_in = root_ff >> 1;
            end
            bp_in = bp_ff - 5'd1;
            if (bp_ff == 5'd0) begin
               len_in   = (root_in[31:0] == '0) ? 32'd1 : root_in[31:0];
               j_in     = 2'd0;
               state_in = ST_DSET;
            end
         end
         ST_DSET: begin
            drem_in  = 32'(num[45:16]);
            numlo_in = num[15:0];
            q_in     = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (dtrial >= {1'b0, len_ff}) begin
               drem_in = 32'(dtrial - {1'b0, len_ff});
               q_in    = {q_ff[14:0], 1'b1};
            end else begin
               drem_in = dtrial[31:0];
               q_in    = {q_ff[14:0], 1'b0};
            end
            numlo_in = {numlo_ff[14:0], 1'b0};
            cnt_in   = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) begin
               state_in = ST_DFIN;
            end
         end
         ST_DFIN: begin
            unique case (j_ff)
               2'd0:    res_nx_in = comp;
               2'd1:    res_ny_in = comp;
               default: res_nz_in = comp;
            endcase
            j_in     = j_ff + 2'd1;
            state_in = (j_ff == 2'd2) ? ST_OUT : ST_DSET;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_nz_ff, res_ny_ff, res_nx_ff, res_h_ff};
               rsp_miss_in  = res_miss_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      bx_ff       <= bx_in;
      bz_ff       <= bz_in;
      lx_ff       <= lx_in;
      lz_ff       <= lz_in;
      k_ff        <= k_in;
      rd_ff       <= rd_in;
      j_ff        <= j_in;
      tx_ff       <= tx_in;
      tz_ff       <= tz_in;
      fx_ff       <= fx_in;
      fz_ff       <= fz_in;
      upper_ff    <= upper_in;
      abase_ff    <= abase_in;
      acc_ff      <= acc_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      va_ff       <= va_in;
      vc_ff       <= vc_in;
      m0_ff       <= m0_in;
      m1_ff       <= m1_in;
      m2_ff       <= m2_in;
      neg0_ff     <= neg0_in;
      neg2_ff     <= neg2_in;
      sq_ff       <= sq_in;
      root_ff     <= root_in;
      bp_ff       <= bp_in;
      len_ff      <= len_in;
      drem_ff     <= drem_in;
      numlo_ff    <= numlo_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      res_h_ff    <= res_h_in;
      res_nx_ff   <= res_nx_in;
      res_ny_ff   <= res_ny_in;
      res_nz_ff   <= res_nz_in;
      res_miss_ff <= res_miss_in;
      rsp_data_ff <= rsp_data_in;
      rsp_miss_ff <= rsp_miss_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_miss_ff;

endmodule
`default_nettype wire

@@ rtl/heightfield_height_and_normal.sv @@
// Heightfield height and normal sampler: top level with the register file.
// A grid write is made in the RAM as it leaves the queue; a height or normal query runs
// through the sequencer states from the head of the queue to the result.
// The sequencer handles one transaction at a time; a normal query takes four grid
// interpolations, a 32-step square root and three 16-step divisions. A 4-entry queue
// decouples input acceptance. Reset is synchronous; the grid holds no reset value.
`default_nettype none
module heightfield_height_and_normal #(
   parameter int CHUNK_TILES    = hhn_pkg::CHUNK_TILES_DEF,
   parameter int TILE_SIZE_LOG2 = hhn_pkg::TILE_SIZE_LOG2_DEF,
   parameter int SAMPLE_BITS    = hhn_pkg::SAMPLE_BITS_DEF,
   localparam int SH   = TILE_SIZE_LOG2 + 8,
   localparam int TW   = $clog2(CHUNK_TILES + 1),
   localparam int LW   = 34 + TW + SH,
   localparam int SIDE = CHUNK_TILES + 1,
   localparam int AW   = $clog2(SIDE * SIDE),
   localparam int SW   = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16,
   localparam int QW   = 3 + 2 * LW + AW + SW
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // pos_x, pos_z, grid_row, grid_col, sample
   input  logic [1:0]  req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // height, normal_x, normal_y, normal_z
   output logic [0:0]  rsp_tuser,  // chunk_missing
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   import hhn_pkg::*;

   logic               present_ff;
   logic signed [15:0] chunk_x_ff, chunk_z_ff;
   logic [15:0]        scale_ff;
   logic               q_push, q_pop, q_full, q_empty;
   logic [QW-1:0]      q_wdata, q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         chunk_x_ff <= '0;
         chunk_z_ff <= '0;
         scale_ff   <= SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PRESENT: present_ff <= csr_wdata[0];
            REG_CHUNK_X: chunk_x_ff <= csr_wdata;
            REG_CHUNK_Z: chunk_z_ff <= csr_wdata;
            REG_SCALE:   scale_ff   <= csr_wdata;
            default:     present_ff <= present_ff;
         endcase
      end
   end

   assign req_tready = !q_full;

   hhn_front #(
      .CHUNK_TILES    (CHUNK_TILES),
      .TILE_SIZE_LOG2 (TILE_SIZE_LOG2),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_front (
      .accept   (req_tvalid && req_tready),
      .command  (req_tuser),
      .pos_x    (req_tdata[31:0]),
      .pos_z    (req_tdata[63:32]),
      .grid_row (req_tdata[69:64]),
      .grid_col (req_tdata[75:70]),
      .sample   (req_tdata[91:76]),
      .present  (present_ff),
      .chunk_x  (chunk_x_ff),
      .chunk_z  (chunk_z_ff),
      .push     (q_push),
      .qdata    (q_wdata)
   );

   hhn_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   hhn_back #(
      .CHUNK_TILES    (CHUNK_TILES),
      .TILE_SIZE_LOG2 (TILE_SIZE_LOG2),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_rdata    (q_rdata),
      .q_pop      (q_pop),
      .scale      (scale_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

@@ sim/heightfield_checker.sv @@
// Checker for the heightfield height and normal sampler: watches the request, response
// and register ports, predicts each result and compares it field by field.
// Depends on hhn_pkg for the command and register codes, the default geometry and the result constants.
`default_nettype none
module heightfield_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [95:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [79:0] rsp_tdata,
   input  wire logic [0:0]  rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               errors,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import hhn_pkg::*;

   localparam int     TILES = CHUNK_TILES_DEF;
   localparam int     SIDE  = TILES + 1;
   localparam int     SH    = TILE_SIZE_LOG2_DEF + 8;
   localparam longint D     = longint'(1) << SH;

   typedef struct {
      logic signed [31:0] height;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               missing;
   } sample_result_type;

   sample_result_type due_results[$];
   int                grid_mirror[SIDE * SIDE];
   logic              present_q;
   longint            chunk_x_q;
   longint            chunk_z_q;
   longint            scale_q;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint terrain_height(longint px, longint pz);
      longint lx, lz, tx, tz, fx, fz, h00, h01, h10, h11, sum;
      lx = px - chunk_x_q * TILES * D;
      lz = pz - chunk_z_q * TILES * D;
      tx = clamp(lx >>> SH, 0, TILES - 1);
      tz = clamp(lz >>> SH, 0, TILES - 1);
      fx = clamp(lx - tx * D, 0, D);
      fz = clamp(lz - tz * D, 0, D);
      h00 = longint'(grid_mirror[tz * SIDE + tx]);
      h01 = longint'(grid_mirror[tz * SIDE + tx + 1]);
      h10 = longint'(grid_mirror[(tz + 1) * SIDE + tx]);
      h11 = longint'(grid_mirror[(tz + 1) * SIDE + tx + 1]);
      if (fx + fz <= D)
         sum = h00 * (D - fx - fz) + h10 * fz + h01 * fx;
      else
         sum = h11 * (fx + fz - D) + h01 * (D - fz) + h10 * (D - fx);
      return (sum * scale_q) >>> SH;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] unit_component(longint v, longint unsigned len);
      longint unsigned a, q;
      a = (v < 0) ? -v : v;
      q = (a * ONE_Q14 + len / 2) / len;
      if (q > ONE_Q14) q = ONE_Q14;
      return (v < 0) ? -16'(q) : 16'(q);
   endfunction

   function automatic sample_result_type query_result(logic [1:0] cmd, longint px,
                                                      longint pz);
      sample_result_type r;
      longint            v[3], hh;
      longint unsigned   m[3], mx, len;
      int                s;
      r = '{height: 0, nx: 0, ny: 0, nz: 0, missing: !present_q};
      if (cmd == CMD_HEIGHT) begin
         if (!present_q) begin
            r.height = MISS_HEIGHT;
         end else begin
            hh = clamp(terrain_height(px, pz), -64'sd2147483648, 64'sd2147483647);
            r.height = 32'(hh);
         end
      end else if (!present_q) begin
         r.ny = 16'(ONE_Q14);
      end else begin
         v[0] = terrain_height(px - EPS_Q8, pz) - terrain_height(px + EPS_Q8, pz);
         v[1] = 2 * EPS_Q8;
         v[2] = terrain_height(px, pz - EPS_Q8) - terrain_height(px, pz + EPS_Q8);
         for (int i = 0; i < 3; i++) m[i] = (v[i] < 0) ? -v[i] : v[i];
         mx = (m[0] > m[1]) ? m[0] : m[1];
         if (m[2] > mx) mx = m[2];
         s = 0;
         while ((mx >> s) >= (64'd1 << 30)) s++;
         for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> s;
            v[i] = (v[i] < 0) ? -longint'(m[i]) : longint'(m[i]);
         end
         len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
         if (len == 0) len = 1;
         r.nx = unit_component(v[0], len);
         r.ny = unit_component(v[1], len);
         r.nz = unit_component(v[2], len);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      sample_result_type want;
      logic [5:0]        row, col;
      if (reset) begin
         present_q = 1'b0;
         chunk_x_q = 0;
         chunk_z_q = 0;
         scale_q   = longint'(SCALE_RESET);
         due_results.delete();
         errors    = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("response transaction with no result expected");
               errors++;
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[31:0] !== want.height) begin
                  $error("height: expected %0d, got %0d", want.height,
                         $signed(rsp_tdata[31:0]));
                  errors++;
               end
               if (rsp_tdata[47:32] !== want.nx) begin
                  $error("normal_x: expected %0d, got %0d", want.nx,
                         $signed(rsp_tdata[47:32]));
                  errors++;
               end
               if (rsp_tdata[63:48] !== want.ny) begin
                  $error("normal_y: expected %0d, got %0d", want.ny,
                         $signed(rsp_tdata[63:48]));
                  errors++;
               end
               if (rsp_tdata[79:64] !== want.nz) begin
                  $error("normal_z: expected %0d, got %0d", want.nz,
                         $signed(rsp_tdata[79:64]));
                  errors++;
               end
               if (rsp_tuser[0] !== want.missing) begin
                  $error("chunk_missing: expected %0d, got %0d", want.missing, rsp_tuser[0]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            row = req_tdata[69:64];
            col = req_tdata[75:70];
            if (req_tuser == CMD_WRITE) begin
               if (row <= TILES && col <= TILES)
                  grid_mirror[row * SIDE + col] = int'($signed(req_tdata[91:76]));
            end else if (req_tuser == CMD_HEIGHT || req_tuser == CMD_NORMAL) begin
               due_results.insert(due_results.size(),
                                  query_result(req_tuser,
                                               longint'($signed(req_tdata[31:0])),
                                               longint'($signed(req_tdata[63:32]))));
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_PRESENT: present_q = csr_wdata[0];
               REG_CHUNK_X: chunk_x_q = longint'($signed(csr_wdata));
               REG_CHUNK_Z: chunk_z_q = longint'($signed(csr_wdata));
               REG_SCALE:   scale_q   = longint'(csr_wdata);
               default: ;
            endcase
         end
      end
      outstanding = due_results.size();
   end

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Top of the heightfield sampler testbench: clock, reset, request and register stimulus,
// response back-pressure and the verdict. Depends on hhn_pkg, the block and
// heightfield_checker.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hhn_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [1:0]  req_tuser = CMD_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_PRESENT;
   logic [15:0] csr_wdata = '0;
   int          errors;
   int          outstanding;
   int          sent = 0;
   logic        eager = 1'b0;
   logic signed [15:0] cur_cx = '0;
   logic signed [15:0] cur_cz = '0;

   heightfield_height_and_normal i_dut (.*);

   heightfield_checker i_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 11) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic offer(logic [1:0] cmd, logic [31:0] px, logic [31:0] pz,
                        logic [5:0] row, logic [5:0] col, logic [15:0] smp);
      int gap;
      gap = eager ? 0 : random_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, smp, col, row, pz, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   task automatic configure(logic present, logic [15:0] cx, logic [15:0] cz,
                            logic [15:0] scale);
      logic [15:0] vals[4];
      vals = '{{15'b0, present}, cx, cz, scale};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cur_cx = cx;
      cur_cz = cz;
   endtask

   function automatic logic [31:0] position(logic signed [15:0] c);
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 32'(longint'(c) * 8192 + $urandom_range(0, 9200) - 500);
      if (r < 9) return $urandom;
      return 32'(longint'(c) * 8192 + (($urandom_range(0, 1) == 1) ? 8192 : 0));
   endfunction

   task automatic random_items(int count);
      int          r;
      logic [5:0]  row, col;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) eager = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         row = 6'($urandom_range(0, 32));
         col = 6'($urandom_range(0, 32));
         if (r < 5) begin
            row = 6'($urandom);
            col = 6'($urandom);
         end
         if (r < 22)
            offer(CMD_WRITE, $urandom, $urandom, row, col, 16'($urandom));
         else if (r < 26)
            offer(CMD_UNUSED, $urandom, $urandom, 6'($urandom), 6'($urandom),
                  16'($urandom));
         else if (r < 63)
            offer(CMD_HEIGHT, position(cur_cx), position(cur_cz), 6'($urandom),
                  6'($urandom), 16'($urandom));
         else
            offer(CMD_NORMAL, position(cur_cx), position(cur_cz), 6'($urandom),
                  6'($urandom), 16'($urandom));
      end
      eager = 1'b0;
   endtask

   initial begin
      logic held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && sent >= 1300) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 2) != 0);
            repeat (random_gap() + 1) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every grid entry is written before any query can read it.
      for (int row = 0; row <= CHUNK_TILES_DEF; row++)
         for (int col = 0; col <= CHUNK_TILES_DEF; col++)
            offer(CMD_WRITE, $urandom, $urandom, 6'(row), 6'(col), 16'($urandom));

      offer(CMD_HEIGHT, 32'd100, 32'd100, '0, '0, '0);
      offer(CMD_NORMAL, 32'd100, 32'd100, '0, '0, '0);
      settle();
      configure(1'b1, 16'd0, 16'd0, SCALE_RESET);
      offer(CMD_WRITE, '0, '0, 6'd0, 6'd0, 16'h8000);
      offer(CMD_WRITE, '0, '0, 6'd32, 6'd32, 16'h7fff);
      offer(CMD_WRITE, '0, '0, 6'd33, 6'd0, 16'h1234);
      offer(CMD_WRITE, '0, '0, 6'd0, 6'd63, 16'h1234);
      offer(CMD_WRITE, '0, '0, 6'd63, 6'd63, 16'hffff);
      offer(CMD_UNUSED, 32'hffffffff, 32'hffffffff, 6'd63, 6'd63, 16'hffff);
      offer(CMD_HEIGHT, 32'd0, 32'd0, '0, '0, '0);
      offer(CMD_HEIGHT, 32'd128, 32'd128, '0, '0, '0);
      offer(CMD_HEIGHT, 32'd129, 32'd128, '0, '0, '0);
      offer(CMD_HEIGHT, 32'd8192, 32'd8192, '0, '0, '0);
      offer(CMD_HEIGHT, 32'h7fffffff, 32'h80000000, '0, '0, '0);
      offer(CMD_HEIGHT, 32'hffffffff, 32'hffffffff, '0, '0, '0);
      offer(CMD_NORMAL, 32'd0, 32'd0, '0, '0, '0);
      offer(CMD_NORMAL, 32'd4000, 32'd4000, '0, '0, '0);
      offer(CMD_NORMAL, 32'd8192, 32'd8192, '0, '0, '0);
      offer(CMD_NORMAL, 32'h80000000, 32'h7fffffff, '0, '0, '0);
      random_items(80);
      settle();
      configure(1'b1, 16'h8000, 16'h7fff, 16'hffff);
      random_items(70);
      settle();
      configure(1'b1, 16'h7fff, 16'h8000, 16'h0000);
      random_items(60);
      settle();
      configure(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
      random_items(70);
      settle();
      configure(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
      random_items(40);
      settle();
      configure(1'b1, 16'hffff, 16'h0001, 16'h0001);
      random_items(70);
      settle();
      configure(1'b1, 16'h0000, 16'hffff, 16'h0100);
      random_items(60);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire

@@ heightfield_height_and_normal.f @@
rtl/hhn_pkg.sv
rtl/hhn_ram.sv
rtl/hhn_fifo.sv
rtl/hhn_front.sv
rtl/hhn_back.sv
rtl/heightfield_height_and_normal.sv
sim/heightfield_checker.sv
sim/testbench.sv
